@@ rtl/core/mi3_pkg.sv @@
// shared widths, types and index tables for the 3x3 matrix inverse unit
// no dependencies; imported by every module of the unit
package mi3_pkg;

	localparam int EW   = 32;          // entry width
	localparam int FB   = 16;          // fraction bits
	localparam int PW   = 2 * EW;      // entry product width
	localparam int AW   = 2 * EW + 1;  // adjugate entry width
	localparam int LB   = EW + 1;      // low slice of an adjugate entry
	localparam int PLW  = EW + LB + 1; // low partial product width
	localparam int DXW  = 3 * EW + 1;  // exact determinant width
	localparam int DW   = 64;          // determinant output width
	localparam int NW   = 3 * EW;      // numerator and divisor magnitude width
	localparam int NMW  = 2 * EW;      // adjugate magnitude width
	localparam int QB   = EW;          // quotient bits kept
	localparam int DIV_LAT = QB + 2;   // divider lane latency

	typedef logic signed [EW-1:0]  entry_t;
	typedef logic signed [PW-1:0]  prod_t;
	typedef logic signed [AW-1:0]  adj_t;
	typedef logic signed [PLW-1:0] plo_t;
	typedef logic signed [DXW-1:0] dx_t;
	typedef logic signed [DW-1:0]  det_t;
	typedef logic [NW-1:0]         mag_t;

	typedef struct packed {
		logic valid;
		logic singular;
		logic neg;
	} ctl_t;

	// operand indexes a,b,c,d of each cofactor a*b - c*d, row-major adjugate order
	localparam int COF_IDX [0:8][0:3] = '{
		'{4, 8, 7, 5},
		'{2, 7, 1, 8},
		'{1, 5, 2, 4},
		'{5, 6, 3, 8},
		'{0, 8, 2, 6},
		'{3, 2, 0, 5},
		'{3, 7, 6, 4},
		'{6, 1, 0, 7},
		'{0, 4, 3, 1}
	};

endpackage

@@ rtl/core/mi3_cofactor.sv @@
// two-stage adjugate: eighteen entry products, then nine cofactor differences
// depends on mi3_pkg
module mi3_cofactor import mi3_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  entry_t m [9],
	output logic   out_valid,
	output adj_t   adj [9],
	output entry_t row0 [3]
);

	logic   valid_s1, valid_s2;
	prod_t  p_s1 [18];
	entry_t row0_s1 [3];
	entry_t row0_s2 [3];
	adj_t   adj_s2 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_cof
		always_ff @(posedge clk) begin
			if (en) begin
				p_s1[2*k]   <= PW'(m[COF_IDX[k][0]]) * PW'(m[COF_IDX[k][1]]);
				p_s1[2*k+1] <= PW'(m[COF_IDX[k][2]]) * PW'(m[COF_IDX[k][3]]);
				adj_s2[k]   <= AW'(p_s1[2*k]) - AW'(p_s1[2*k+1]);
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		always_ff @(posedge clk) begin
			if (en) begin
				row0_s1[i] <= m[i];
				row0_s2[i] <= row0_s1[i];
			end
		end
		assign row0[i] = row0_s2[i];
	end

	assign out_valid = valid_s2;
	assign adj       = adj_s2;

endmodule

@@ rtl/core/mi3_det.sv @@
// determinant by first-row expansion, then divider operands, over four stages
// depends on mi3_pkg
module mi3_det import mi3_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   emit_transposed,
	input  logic   in_valid,
	input  adj_t   adj [9],
	input  entry_t row0 [3],
	output ctl_t   ctl [9],
	output mag_t   num [9],
	output mag_t   den,
	output det_t   det_out
);

	logic valid_s3, valid_s4, valid_s5;
	plo_t  pl_s3 [3];
	prod_t ph_s3 [3];
	dx_t   prod_s4 [3];
	dx_t   det_s5;
	adj_t  adj_s3 [9];
	adj_t  adj_s4 [9];
	adj_t  adj_s5 [9];
	ctl_t  ctl_s6 [9];
	mag_t  num_s6 [9];
	mag_t  den_s6;
	det_t  det_s6;

	logic                dneg, dzero;
	logic signed [DXW-2*FB-1:0] dsh;
	mag_t                dmag;
	det_t                dsat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// split each 65-bit first-row cofactor into an unsigned low part and a signed high part
	for (genvar i = 0; i < 3; i++) begin : g_part
		always_ff @(posedge clk) begin
			if (en) begin
				pl_s3[i]   <= PLW'(row0[i]) * PLW'($signed({1'b0, adj[3*i][LB-1:0]}));
				ph_s3[i]   <= PW'(row0[i]) * PW'($signed(adj[3*i][AW-1:LB]));
				prod_s4[i] <= (DXW'(ph_s3[i]) <<< LB) + DXW'(pl_s3[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adj_s3 <= adj;
			adj_s4 <= adj_s3;
			adj_s5 <= adj_s4;
			det_s5 <= prod_s4[0] + prod_s4[1] + prod_s4[2];
		end
	end

	always_comb begin
		dneg  = det_s5[DXW-1];
		dzero = (det_s5 == '0);
		dmag  = dneg ? NW'(-det_s5) : NW'(det_s5);
		dsh   = det_s5[DXW-1:2*FB];
		// keep 64 bits when the shifted value fits, otherwise clamp
		if (dsh[$bits(dsh)-1] == dsh[DW-1])
			dsat = dsh[DW-1:0];
		else
			dsat = dsh[$bits(dsh)-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
	end

	for (genvar k = 0; k < 9; k++) begin : g_num
		localparam int SRC_T = 3 * (k % 3) + (k / 3);
		adj_t              a;
		logic [NMW-1:0]    amag;
		assign a    = emit_transposed ? adj_s5[SRC_T] : adj_s5[k];
		assign amag = a[AW-1] ? NMW'(-a) : NMW'(a);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s6[k] <= '0;
			end else if (en) begin
				ctl_s6[k] <= '{valid: valid_s5, singular: dzero, neg: a[AW-1] ^ dneg};
			end
		end
		always_ff @(posedge clk) begin
			if (en) num_s6[k] <= NW'({amag, {(2*FB){1'b0}}});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6 <= dmag;
			det_s6 <= dsat;
		end
	end

	assign ctl     = ctl_s6;
	assign num     = num_s6;
	assign den     = den_s6;
	assign det_out = det_s6;

endmodule

@@ rtl/core/mi3_div.sv @@
// one divider lane: restoring division, one quotient bit per stage, then saturation
// depends on mi3_pkg
module mi3_div import mi3_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  ctl_t   ctl_in,
	input  mag_t   num,
	input  mag_t   den,
	output ctl_t   ctl_out,
	output entry_t res
);

	mag_t           rem_s [QB+1];
	mag_t           den_s [QB+1];
	logic [QB-1:0]  quo_s [QB+1];
	logic           ov_s  [QB+1];
	ctl_t           ctl_s [QB+1];
	ctl_t           ctl_f;
	entry_t         res_f;
	entry_t         sat_v;

	// stage 0: quotient beyond the kept bits means saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s[0] <= '0;
		else if (en) ctl_s[0] <= ctl_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ov_s[0]  <= ({{QB{1'b0}}, num} >= {den, {QB{1'b0}}});
		end
	end

	for (genvar t = 1; t <= QB; t++) begin : g_step
		localparam int B = QB - t;
		logic [NW+QB-1:0] rx, dx, diff;
		logic             ge;
		assign rx   = {{QB{1'b0}}, rem_s[t-1]};
		assign dx   = {{QB{1'b0}}, den_s[t-1]} << B;
		assign ge   = (rx >= dx);
		assign diff = rx - dx;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_s[t] <= '0;
			else if (en) ctl_s[t] <= ctl_s[t-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[t]    <= ge ? diff[NW-1:0] : rem_s[t-1];
				den_s[t]    <= den_s[t-1];
				quo_s[t]    <= quo_s[t-1] | (ge ? (QB'(1) << B) : '0);
				ov_s[t]     <= ov_s[t-1];
			end
		end
	end

	always_comb begin
		priority if (ctl_s[QB].singular)
			sat_v = '0;
		else if (!ctl_s[QB].neg) begin
			if (ov_s[QB] || quo_s[QB][QB-1])
				sat_v = {1'b0, {(EW-1){1'b1}}};
			else
				sat_v = EW'(quo_s[QB]);
		end else begin
			if (ov_s[QB] || (quo_s[QB] > {1'b1, {(QB-1){1'b0}}}))
				sat_v = {1'b1, {(EW-1){1'b0}}};
			else
				sat_v = EW'(-quo_s[QB]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_f <= '0;
		else if (en) ctl_f <= ctl_s[QB];
	end

	always_ff @(posedge clk) begin
		if (en) res_f <= sat_v;
	end

	assign ctl_out = ctl_f;
	assign res     = res_f;

endmodule

@@ rtl/core/matrix3x3_inverse_with_determinant_unit.sv @@
// top level of the 3x3 fixed-point matrix inverse unit
// depends on mi3_pkg, mi3_cofactor, mi3_det, mi3_div
//
// usage:
//   input channel in_valid/in_stall carries one matrix m00..m22 per beat,
//   signed Q16.16. output channel out_valid/out_stall carries the inverse
//   r00..r22 (or its transpose when emit_transposed is set), the determinant
//   and the singular flag. a singular matrix gives a zero inverse.
//   config channel cfg_valid/cfg_ready writes emit_transposed from cfg_data[0];
//   cfg_ready is always high. write it only while the unit is empty.
// timing:
//   an accepted input beat reaches its output beat through two adjugate
//   stages, four determinant stages, and a divider lane of 34 stages per
//   entry that yields one quotient bit in each of its divide steps.
//   throughput is one matrix per cycle while the output is not stalled.
// stall:
//   the whole pipeline holds when a result waits under out_stall; in_stall is
//   then raised and nothing is lost or repeated.
// reset:
//   arst_n clears all valid bits and sets emit_transposed to 0.
module matrix3x3_inverse_with_determinant_unit import mi3_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic   out_valid,
	input  logic   out_stall,
	output entry_t r00, r01, r02, r10, r11, r12, r20, r21, r22,
	output det_t   determinant,
	output logic   singular,
	input  logic   cfg_valid,
	output logic   cfg_ready,
	input  logic   cfg_data
);

	logic   en;
	logic   emit_q;
	entry_t m [9];
	adj_t   adj [9];
	entry_t row0 [3];
	logic   cof_valid;
	ctl_t   dctl [9];
	mag_t   num [9];
	mag_t   den;
	det_t   det_v;
	ctl_t   lctl [9];
	entry_t res [9];
	det_t   det_pipe_q [DIV_LAT];

	assign en        = !out_valid || !out_stall;
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) emit_q <= 1'b0;
		else if (cfg_valid && cfg_ready) emit_q <= cfg_data;
	end

	assign m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

	mi3_cofactor u_cof (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.m         (m),
		.out_valid (cof_valid),
		.adj       (adj),
		.row0      (row0)
	);

	mi3_det u_det (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.emit_transposed (emit_q),
		.in_valid        (cof_valid),
		.adj             (adj),
		.row0            (row0),
		.ctl             (dctl),
		.num             (num),
		.den             (den),
		.det_out         (det_v)
	);

	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (dctl[k]),
			.num     (num[k]),
			.den     (den),
			.ctl_out (lctl[k]),
			.res     (res[k])
		);
	end

	// determinant rides alongside the divider lanes
	always_ff @(posedge clk) begin
		if (en) begin
			det_pipe_q[0] <= det_v;
			for (int i = 1; i < DIV_LAT; i++) det_pipe_q[i] <= det_pipe_q[i-1];
		end
	end

	assign out_valid   = lctl[0].valid;
	assign singular    = lctl[0].singular;
	assign determinant = det_pipe_q[DIV_LAT-1];
	assign r00 = res[0];
	assign r01 = res[1];
	assign r02 = res[2];
	assign r10 = res[3];
	assign r11 = res[4];
	assign r12 = res[5];
	assign r20 = res[6];
	assign r21 = res[7];
	assign r22 = res[8];

	// all lanes share one valid pattern; the other lanes' control bits are only folded together here so they count as used
	logic lanes_agree;
	assign lanes_agree = lctl[1].valid & lctl[2].valid & lctl[3].valid & lctl[4].valid
		& lctl[5].valid & lctl[6].valid & lctl[7].valid & lctl[8].valid
		& lctl[1].singular & lctl[2].singular & lctl[3].singular & lctl[4].singular
		& lctl[5].singular & lctl[6].singular & lctl[7].singular & lctl[8].singular
		& lctl[0].neg & lctl[1].neg & lctl[2].neg & lctl[3].neg & lctl[4].neg
		& lctl[5].neg & lctl[6].neg & lctl[7].neg & lctl[8].neg;
	logic unused_ok;
	assign unused_ok = lanes_agree;

endmodule

@@ rtl/core/mi3_checker.sv @@
// port-level checks for the 3x3 matrix inverse unit, bound to the top level
// depends on mi3_pkg and matrix3x3_inverse_with_determinant_unit
module mi3_checker import mi3_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_stall,
	input logic   out_valid,
	input logic   out_stall,
	input entry_t r00,
	input entry_t r11,
	input entry_t r22,
	input det_t   determinant,
	input logic   singular
);

	// a blocked result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(r00) && $stable(determinant))
		else $error("output beat changed while stalled");

	// a singular matrix shows a zero determinant and zeros on the diagonal of the inverse
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> r00 == '0 && r11 == '0 && r22 == '0 && determinant == '0)
		else $error("singular beat with nonzero payload");

	// input is held back only by a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

endmodule

bind matrix3x3_inverse_with_determinant_unit mi3_checker u_mi3_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.r00         (r00),
	.r11         (r11),
	.r22         (r22),
	.determinant (determinant),
	.singular    (singular)
);
